// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker ors_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define ORS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, quiet while reset is held
`define ORS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/ors_pkg.sv -----
`default_nettype none

package ors_pkg;

    // action codes
    localparam logic [1:0] ACT_FIRST = 2'd0;
    localparam logic [1:0] ACT_NEXT  = 2'd1;
    localparam logic [1:0] ACT_BIT   = 2'd2;

    // status codes
    localparam logic [2:0] ST_BIT     = 3'd0;
    localparam logic [2:0] ST_CMD     = 3'd1;
    localparam logic [2:0] ST_FOUND   = 3'd2;
    localparam logic [2:0] ST_END     = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    localparam logic [6:0] LAST_BIT     = 7'd64;
    localparam logic [6:0] FAMILY_LIMIT = 7'd9;
    localparam logic [7:0] CRC_POLY     = 8'h8C;

    typedef struct packed {
        logic [1:0] action;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        direction_bit;
        logic [63:0] rom_id;
        logic [3:0]  family_discrepancy;
    } out_t;

    typedef struct packed {
        logic [63:0] rom_bits;
        logic [6:0]  last_disc;
        logic [3:0]  family_disc;
        logic        last_device;
        logic        searching;
        logic [6:0]  bit_pos;
        logic [6:0]  zero_mark;
        logic [7:0]  crc;
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/ors_decide.sv -----
`default_nettype none

module ors_decide (
    input  ors_pkg::state_t cur,
    input  ors_pkg::in_t    item,
    output ors_pkg::state_t nxt,
    output ors_pkg::out_t   res
);

    logic [5:0] idx;
    logic       dir;
    logic       fb;
    logic [7:0] crc_n;

    assign idx = 6'(cur.bit_pos - 7'd1);

    always_comb begin
        nxt   = cur;
        res   = '0;
        res.status = ors_pkg::ST_IGNORED;
        dir   = 1'b0;
        fb    = 1'b0;
        crc_n = cur.crc;
        unique case (item.action) inside
            ors_pkg::ACT_FIRST, ors_pkg::ACT_NEXT: begin
                if (item.action == ors_pkg::ACT_FIRST) begin
                    nxt.last_disc   = '0;
                    nxt.last_device = 1'b0;
                    nxt.family_disc = '0;
                end
                nxt.bit_pos   = 7'd1;
                nxt.zero_mark = '0;
                nxt.crc       = '0;
                nxt.searching = 1'b0;
                if (nxt.last_device || !item.presence) begin
                    nxt.last_disc   = '0;
                    nxt.family_disc = '0;
                    nxt.last_device = 1'b0;
                    res.status      = ors_pkg::ST_END;
                end else begin
                    nxt.searching = 1'b1;
                    res.status    = ors_pkg::ST_CMD;
                end
            end
            ors_pkg::ACT_BIT: begin
                if (cur.searching) begin
                    if (item.id_bit && item.complement_bit) begin
                        // nobody on the bus answered
                        nxt.last_disc   = '0;
                        nxt.family_disc = '0;
                        nxt.last_device = 1'b0;
                        nxt.searching   = 1'b0;
                        res.status      = ors_pkg::ST_END;
                    end else begin
                        if (item.id_bit != item.complement_bit) begin
                            dir = item.id_bit;
                        end else begin
                            // discrepancy: follow last pass below the mark, take 1 at it, 0 above it
                            if (cur.bit_pos < cur.last_disc) begin
                                dir = cur.rom_bits[idx];
                            end else begin
                                dir = (cur.bit_pos == cur.last_disc);
                            end
                            if (!dir) begin
                                nxt.zero_mark = cur.bit_pos;
                                if (cur.bit_pos < ors_pkg::FAMILY_LIMIT) begin
                                    nxt.family_disc = cur.bit_pos[3:0];
                                end
                            end
                        end
                        nxt.rom_bits[idx] = dir;
                        // bit-serial crc-8, lsb first
                        fb    = cur.crc[0] ^ dir;
                        crc_n = {1'b0, cur.crc[7:1]} ^ (fb ? ors_pkg::CRC_POLY : 8'h00);
                        nxt.crc     = crc_n;
                        nxt.bit_pos = 7'(cur.bit_pos + 7'd1);
                        res.direction_bit = dir;
                        if (cur.bit_pos != ors_pkg::LAST_BIT) begin
                            res.status = ors_pkg::ST_BIT;
                        end else begin
                            nxt.searching = 1'b0;
                            if (crc_n == 8'h00 && nxt.rom_bits[7:0] != 8'h00) begin
                                nxt.last_disc = nxt.zero_mark;
                                if (nxt.zero_mark == 7'd0) begin
                                    nxt.last_device = 1'b1;
                                end
                                res.status = ors_pkg::ST_FOUND;
                            end else begin
                                nxt.last_disc   = '0;
                                nxt.family_disc = '0;
                                nxt.last_device = 1'b0;
                                res.status      = ors_pkg::ST_END;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.rom_id             = nxt.rom_bits;
        res.family_discrepancy = nxt.family_disc;
    end

endmodule

`default_nettype wire

// ----- rtl/onewire_rom_search_engine.sv -----
// an accepted input beat gives its result beat on m_ in the next cycle
// throughput: one item per cycle, held back only while a result waits on m_ready
// search state and result register update together at the input beat
// reset (aresetn low, synchronous): search state cleared, bit position 1, no result pending
`default_nettype none

module onewire_rom_search_engine (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_valid,
    output logic           s_ready,
    input  ors_pkg::in_t   s_data,
    output logic           m_valid,
    input  wire            m_ready,
    output ors_pkg::out_t  m_data
);

    ors_pkg::state_t state_reg;
    ors_pkg::state_t state_next;
    ors_pkg::out_t   res_reg;
    ors_pkg::out_t   res_next;
    logic            m_valid_reg;
    logic            accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

    ors_decide u_decide (
        .cur  (state_reg),
        .item (s_data),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= '0;
            state_reg.bit_pos <= 7'd1;
            m_valid_reg       <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ors_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module ors_checker (
    input wire           aclk,
    input wire           aresetn,
    input wire           s_valid,
    input wire           s_ready,
    input ors_pkg::in_t  s_data,
    input wire           m_valid,
    input wire           m_ready,
    input ors_pkg::out_t m_data
);

    // a stalled result beat holds
    `ORS_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // every input beat shows up as a result the next cycle
    `ORS_ASSERT_NEXT(a_result, aclk, aresetn, s_valid && s_ready, m_valid)
    // an empty output stage never stalls the input
    `ORS_ASSERT_IMPLY(a_ready, aclk, aresetn, !m_valid, s_ready)
    // a found device always has a nonzero family byte
    `ORS_ASSERT_IMPLY(a_family, aclk, aresetn,
        m_valid && m_data.status == ors_pkg::ST_FOUND, m_data.rom_id[7:0] != 8'h00)
    // a command beat only answers a start beat
    `ORS_ASSERT_NEXT(a_cmd, aclk, aresetn,
        s_valid && s_ready && s_data.action == ors_pkg::ACT_BIT,
        m_data.status != ors_pkg::ST_CMD)

endmodule

bind onewire_rom_search_engine ors_checker u_ors_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
